>>> sv/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// r2fft_pkg: shared types and constants of the radix-2 complex FFT
// Twiddle table, sequencer states and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package r2fft_pkg;
  localparam int DEF_MAX_LOG2_POINTS = 6;
  localparam int DEF_SAMPLE_WIDTH    = 16;
  localparam int TABLE_LOG2          = 5;
  localparam int TW_WIDTH            = 17;
  localparam int CFG_INDEX_WIDTH     = 1;
  localparam int CFG_DATA_WIDTH      = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOG2_POINTS = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FORWARD     = 1'd1;

  typedef enum logic [2:0] {
    ST_LOAD, ST_REV_RD, ST_REV_WR, ST_BF_RD, ST_BF_WAIT, ST_BF_WR, ST_OUT_RD, ST_OUT
  } state_t;

  // cos(pi*k/32) in Q1.15, quarter wave.
  function automatic logic signed [TW_WIDTH-1:0] quarter_cos(input logic [4:0] i);
    case (i)
      5'd0:  quarter_cos = 17'sd32767;
      5'd1:  quarter_cos = 17'sd32610;
      5'd2:  quarter_cos = 17'sd32138;
      5'd3:  quarter_cos = 17'sd31357;
      5'd4:  quarter_cos = 17'sd30274;
      5'd5:  quarter_cos = 17'sd28899;
      5'd6:  quarter_cos = 17'sd27246;
      5'd7:  quarter_cos = 17'sd25330;
      5'd8:  quarter_cos = 17'sd23170;
      5'd9:  quarter_cos = 17'sd20788;
      5'd10: quarter_cos = 17'sd18205;
      5'd11: quarter_cos = 17'sd15447;
      5'd12: quarter_cos = 17'sd12540;
      5'd13: quarter_cos = 17'sd9512;
      5'd14: quarter_cos = 17'sd6393;
      5'd15: quarter_cos = 17'sd3212;
      default: quarter_cos = 17'sd0;
    endcase
  endfunction

  function automatic logic signed [TW_WIDTH-1:0] table_cos(input logic [4:0] k);
    if (k <= 5'd16) table_cos = quarter_cos(k);
    else            table_cos = -quarter_cos(5'(6'd32 - {1'b0, k}));
  endfunction

  function automatic logic signed [TW_WIDTH-1:0] table_sin(input logic [4:0] k);
    if (k <= 5'd16) table_sin = quarter_cos(5'(5'd16 - k));
    else            table_sin = quarter_cos(5'(k - 5'd16));
  endfunction
endpackage
`default_nettype wire

>>> sv/r2fft_stream_if.sv
// ----------------------------------------------------------------------------
// r2fft_stream_if: valid/ready channel carrying one complex sample beat
// Also carries the last and saturation flags used on the result side.
// ----------------------------------------------------------------------------
`default_nettype none
interface r2fft_stream_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_real;
  logic signed [SAMPLE_WIDTH-1:0] sample_imag;
  logic                           last_result;
  logic                           saturated;
  modport source (output valid, sample_real, sample_imag, last_result, saturated,
                  input ready);
  modport sink   (input valid, sample_real, sample_imag, last_result, saturated,
                  output ready);
endinterface
`default_nettype wire

>>> sv/radix2_complex_fft.sv
// ----------------------------------------------------------------------------
// radix2_complex_fft: in-place radix-2 DIT FFT over up to 2^MAX_LOG2_POINTS points
// ----------------------------------------------------------------------------
// Channel | Direction | Beat contents
// in_     | sink      | sample_real, sample_imag
// out_    | source    | result_real, result_imag, last_result, saturated
// cfg_    | write     | register index, data (log2_points, forward)
//
// Loading accepts one sample per cycle. After the last sample the bit-reverse
// pass visits each entry (ST_REV_RD, ST_REV_WR), the single shared butterfly
// takes one pair at a time (read, wait, write), and each bin is read, then offered.
// The block is not ready for samples while transforming or emitting.
// Reset is synchronous and active low; the sample store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module radix2_complex_fft #(
  parameter int MAX_LOG2_POINTS = r2fft_pkg::DEF_MAX_LOG2_POINTS,
  parameter int SAMPLE_WIDTH    = r2fft_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         in_sample_real,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         in_sample_imag,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]              out_result_real,
  output logic signed [SAMPLE_WIDTH-1:0]              out_result_imag,
  output logic                                        out_last_result,
  output logic                                        out_saturated,
  input  wire logic                                   cfg_write_enable,
  input  wire logic [r2fft_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [r2fft_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
  import r2fft_pkg::*;

  logic [2:0] log2_points_r;
  logic       forward_r;

  r2fft_stream_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) in_ch ();
  r2fft_stream_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) out_ch ();

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_points_r <= 3'd6;
      forward_r     <= 1'b1;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_LOG2_POINTS: log2_points_r <= cfg_data;
        REG_FORWARD:     forward_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ch.valid       = in_valid;
  assign in_ch.sample_real = in_sample_real;
  assign in_ch.sample_imag = in_sample_imag;
  assign in_ch.last_result = 1'b0;
  assign in_ch.saturated   = 1'b0;
  assign in_ready          = in_ch.ready;
  assign out_ch.ready      = out_ready;
  assign out_valid         = out_ch.valid;
  assign out_result_real   = out_ch.sample_real;
  assign out_result_imag   = out_ch.sample_imag;
  assign out_last_result   = out_ch.last_result;
  assign out_saturated     = out_ch.saturated;

  r2fft_ctrl #(.MAX_LOG2_POINTS(MAX_LOG2_POINTS), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .log2_points(log2_points_r), .forward(forward_r),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );
endmodule
`default_nettype wire

>>> sv/r2fft_bfly.sv
// ----------------------------------------------------------------------------
// r2fft_bfly: shared butterfly unit
// Registered complex multiply, then add/subtract with rounding and clamping.
// ----------------------------------------------------------------------------
`default_nettype none
module r2fft_bfly #(
  parameter int SAMPLE_WIDTH = r2fft_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        a_re,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        a_im,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        b_re,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        b_im,
  input  wire logic signed [r2fft_pkg::TW_WIDTH-1:0] w_cos,
  input  wire logic signed [r2fft_pkg::TW_WIDTH-1:0] w_sin,
  input  wire logic                                  fwd,
  output logic signed [SAMPLE_WIDTH-1:0]             x_re,
  output logic signed [SAMPLE_WIDTH-1:0]             x_im,
  output logic signed [SAMPLE_WIDTH-1:0]             y_re,
  output logic signed [SAMPLE_WIDTH-1:0]             y_im,
  output logic                                       clip
);
  import r2fft_pkg::*;
  localparam int PW = SAMPLE_WIDTH + TW_WIDTH + 1;
  localparam int SW = PW + 1;

  logic signed [PW-1:0] t_re_r, t_im_r, a_re_r, a_im_r;
  logic signed [PW-1:0] t_re_nxt, t_im_nxt;
  logic                 fwd_r;
  logic [3:0]           c;

  always_comb begin
    t_re_nxt = PW'(b_re * w_cos) - PW'(b_im * w_sin);
    t_im_nxt = PW'(b_im * w_cos) + PW'(b_re * w_sin);
  end

  always_ff @(posedge clk) begin
    t_re_r <= t_re_nxt;
    t_im_r <= t_im_nxt;
    a_re_r <= PW'(a_re) <<< 15;
    a_im_r <= PW'(a_im) <<< 15;
    fwd_r  <= fwd;
  end

  function automatic logic [SAMPLE_WIDTH:0] finish(input logic signed [SW-1:0] v,
                                                   input logic f);
    logic signed [SW-1:0] r;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = SW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
    lo = -SW'(64'sd1 <<< (SAMPLE_WIDTH - 1));
    if (f) r = (v + (SW'(1) <<< 15)) >>> 16;
    else   r = (v + (SW'(1) <<< 14)) >>> 15;
    if (r > hi)      finish = {1'b1, hi[SAMPLE_WIDTH-1:0]};
    else if (r < lo) finish = {1'b1, lo[SAMPLE_WIDTH-1:0]};
    else             finish = {1'b0, r[SAMPLE_WIDTH-1:0]};
  endfunction

  always_comb begin
    {c[0], x_re} = finish(SW'(a_re_r) + SW'(t_re_r), fwd_r);
    {c[1], x_im} = finish(SW'(a_im_r) + SW'(t_im_r), fwd_r);
    {c[2], y_re} = finish(SW'(a_re_r) - SW'(t_re_r), fwd_r);
    {c[3], y_im} = finish(SW'(a_im_r) - SW'(t_im_r), fwd_r);
    clip = |c;
  end
endmodule
`default_nettype wire

>>> sv/r2fft_ctrl.sv
// ----------------------------------------------------------------------------
// r2fft_ctrl: sequencer and sample store
// Loads samples, bit-reverses in place, runs the butterflies, streams bins.
// ----------------------------------------------------------------------------
`default_nettype none
module r2fft_ctrl #(
  parameter int MAX_LOG2_POINTS = r2fft_pkg::DEF_MAX_LOG2_POINTS,
  parameter int SAMPLE_WIDTH    = r2fft_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [2:0] log2_points,
  input  wire logic       forward,
  r2fft_stream_if.sink    in_ch,
  r2fft_stream_if.source  out_ch
);
  import r2fft_pkg::*;
  localparam int AW = MAX_LOG2_POINTS;
  localparam int DEPTH = 1 << AW;
  localparam int LW = $clog2(MAX_LOG2_POINTS + 1);

  logic [SAMPLE_WIDTH-1:0] mem_re [DEPTH];
  logic [SAMPLE_WIDTH-1:0] mem_im [DEPTH];

  state_t state_r, state_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [LW-1:0] m_r, m_nxt, stage_r, stage_nxt;
  logic [AW:0]   idx_r, idx_nxt;
  logic          fwd_r, fwd_nxt, sat_r, sat_nxt;
  logic [AW-1:0] ra_a, ra_b, wa_a, wa_b;
  logic          we_a, we_b;
  logic [SAMPLE_WIDTH-1:0] wd_a_re, wd_a_im, wd_b_re, wd_b_im;
  logic [SAMPLE_WIDTH-1:0] rd_a_re_r, rd_a_im_r, rd_b_re_r, rd_b_im_r;
  logic signed [SAMPLE_WIDTH-1:0] x_re, x_im, y_re, y_im;
  logic          clip;
  logic [LW-1:0] m_eff;
  logic [AW:0]   npts;
  logic [AW-1:0] rev, top_i, bot_i, half, jmask;
  logic [4:0]    tw_k;
  logic signed [TW_WIDTH-1:0] w_cos, w_sin;

  function automatic logic signed [TW_WIDTH-1:0] forward_sel(
      input logic f, input logic signed [TW_WIDTH-1:0] s);
    forward_sel = f ? -s : s;
  endfunction

  always_comb begin
    if (log2_points == 3'd0) m_eff = LW'(1);
    else if (32'(log2_points) > MAX_LOG2_POINTS) m_eff = LW'(MAX_LOG2_POINTS);
    else m_eff = LW'(log2_points);
  end
  assign npts = (AW+1)'(1) << m_r;

  always_comb begin
    for (int b = 0; b < AW; b++)
      rev[b] = (b < 32'(m_r)) ? idx_r[32'(m_r) - 1 - b] : 1'b0;
  end

  // Butterfly index: insert a zero at bit 'stage' of the pair counter.
  always_comb begin
    half  = AW'(1) << stage_r;
    jmask = half - AW'(1);
    top_i = ((idx_r[AW-1:0] & ~jmask) << 1) | (idx_r[AW-1:0] & jmask);
    bot_i = top_i | half;
    tw_k  = 5'(32'(top_i & jmask) << (TABLE_LOG2 - 32'(stage_r)));
    w_cos = table_cos(tw_k);
    w_sin = forward_sel(fwd_r, table_sin(tw_k));
  end

  r2fft_bfly #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_bfly (
    .clk(clk), .a_re(rd_a_re_r), .a_im(rd_a_im_r), .b_re(rd_b_re_r), .b_im(rd_b_im_r),
    .w_cos(w_cos), .w_sin(w_sin), .fwd(fwd_r),
    .x_re(x_re), .x_im(x_im), .y_re(y_re), .y_im(y_im), .clip(clip)
  );

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_re[wa_a] <= wd_a_re;
      mem_im[wa_a] <= wd_a_im;
    end
    if (we_b) begin
      mem_re[wa_b] <= wd_b_re;
      mem_im[wa_b] <= wd_b_im;
    end
    rd_a_re_r <= mem_re[ra_a];
    rd_a_im_r <= mem_im[ra_a];
    rd_b_re_r <= mem_re[ra_b];
    rd_b_im_r <= mem_im[ra_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      sat_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sat_r   <= sat_nxt;
    end
    m_r     <= m_nxt;
    stage_r <= stage_nxt;
    idx_r   <= idx_nxt;
    fwd_r   <= fwd_nxt;
  end

  assign out_ch.sample_real = rd_a_re_r;
  assign out_ch.sample_imag = rd_a_im_r;
  assign out_ch.saturated   = sat_r;
  assign out_ch.last_result = (idx_r == npts - (AW+1)'(1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; m_nxt = m_r; stage_nxt = stage_r; idx_nxt = idx_r;
    fwd_nxt = fwd_r; sat_nxt = sat_r;
    in_ch.ready = 1'b0; out_ch.valid = 1'b0;
    ra_a = idx_r[AW-1:0]; ra_b = rev;
    we_a = 1'b0; we_b = 1'b0; wa_a = cnt_r[AW-1:0]; wa_b = rev;
    wd_a_re = in_ch.sample_real; wd_a_im = in_ch.sample_imag;
    wd_b_re = rd_a_re_r; wd_b_im = rd_a_im_r;
    case (state_r)
      ST_LOAD: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          we_a = 1'b1;
          cnt_nxt = cnt_r + 7'd1;
          if (32'(cnt_nxt) >= (1 << m_eff)) begin
            cnt_nxt = '0; m_nxt = m_eff; fwd_nxt = forward; sat_nxt = 1'b0;
            idx_nxt = '0; state_nxt = ST_REV_RD;
          end
        end
      end
      ST_REV_RD: state_nxt = ST_REV_WR;
      ST_REV_WR: begin
        // Swap entry with its bit-reversed partner once per pair.
        if (idx_r[AW-1:0] < rev) begin
          we_a = 1'b1; wa_a = idx_r[AW-1:0];
          wd_a_re = rd_b_re_r; wd_a_im = rd_b_im_r;
          we_b = 1'b1;
        end
        idx_nxt = idx_r + (AW+1)'(1);
        state_nxt = ST_REV_RD;
        if (idx_nxt == npts) begin
          idx_nxt = '0; stage_nxt = '0; state_nxt = ST_BF_RD;
        end
      end
      ST_BF_RD: begin
        ra_a = top_i; ra_b = bot_i;
        state_nxt = ST_BF_WAIT;
      end
      ST_BF_WAIT: state_nxt = ST_BF_WR;
      ST_BF_WR: begin
        we_a = 1'b1; wa_a = top_i; wd_a_re = x_re; wd_a_im = x_im;
        we_b = 1'b1; wa_b = bot_i; wd_b_re = y_re; wd_b_im = y_im;
        if (clip) sat_nxt = 1'b1;
        idx_nxt = idx_r + (AW+1)'(1);
        state_nxt = ST_BF_RD;
        if (idx_nxt == (npts >> 1)) begin
          idx_nxt = '0;
          stage_nxt = stage_r + LW'(1);
          if (stage_nxt == m_r) state_nxt = ST_OUT_RD;
        end
      end
      ST_OUT_RD: state_nxt = ST_OUT;
      ST_OUT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          idx_nxt = idx_r + (AW+1)'(1);
          ra_a = idx_nxt[AW-1:0];
          state_nxt = ST_OUT_RD;
          if (idx_nxt == npts) state_nxt = ST_LOAD;
        end else begin
          ra_a = idx_r[AW-1:0];
          state_nxt = ST_OUT;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end
endmodule
`default_nettype wire

>>> sv/r2fft_checker.sv
// ----------------------------------------------------------------------------
// r2fft_checker: port-level checks of the FFT
// Watches the handshakes and the frame marker on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module r2fft_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last_result,
  input wire logic out_saturated
);
  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input ready while results pending");
  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");
  // After the last bin the block returns to loading.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_result |=> !out_valid)
    else $error("results continue after last bin");
  // The saturation flag is the same on every bin of a transform.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_result |=> ##1 out_saturated == $past(out_saturated, 2))
    else $error("saturation flag changed within a frame");
endmodule

bind radix2_complex_fft r2fft_checker u_r2fft_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_last_result(out_last_result), .out_saturated(out_saturated)
);
`default_nettype wire

>>> tb/sv/tb_radix2_complex_fft.sv
// ----------------------------------------------------------------------------
// tb_radix2_complex_fft: self-checking bench for the radix-2 complex FFT
// Streams complex sample frames through the block in both directions and at
// several lengths, predicts every bin in fixed point and compares each result
// beat field by field, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_radix2_complex_fft;
  timeunit 1ns;
  timeprecision 1ps;
  import r2fft_pkg::*;

  localparam int SW = DEF_SAMPLE_WIDTH;
  localparam int MAXN = 1 << DEF_MAX_LOG2_POINTS;

  typedef struct {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic                 last;
    logic                 sat;
  } fft_bin_t;

  class fft_scoreboard;
    logic signed [SW-1:0] re_mem[MAXN];
    logic signed [SW-1:0] im_mem[MAXN];
    logic [2:0] log2_len;
    logic       fwd;
    int unsigned fill;
    logic        clipped;
    fft_bin_t    bins_due[$];
    int errors, frames, bins_seen, sat_frames;
    int quarter[17] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                        23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

    function new();
      log2_len = 3'd6;
      fwd = 1'b1;
      fill = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
      if (idx == REG_LOG2_POINTS) log2_len = val;
      else if (idx == REG_FORWARD) fwd = val[0];
    endfunction

    function longint tw_cos(int k);
      k = k & 31;
      return (k <= 16) ? quarter[k] : -quarter[32 - k];
    endfunction

    function longint tw_sin(int k);
      k = k & 31;
      return (k <= 16) ? quarter[16 - k] : quarter[k - 16];
    endfunction

    function logic signed [SW-1:0] round_clip(longint v, int s);
      longint r;
      r = (v + (longint'(1) << (s - 1))) >>> s;
      if (r > 32767) begin
        clipped = 1'b1;
        return 16'sh7fff;
      end
      if (r < -32768) begin
        clipped = 1'b1;
        return 16'sh8000;
      end
      return r[SW-1:0];
    endfunction

    function void run_fft(int m);
      int n, s, j, r, b;
      longint c, ws, br, bi, tr, ti, ar, ai;
      logic signed [SW-1:0] t;
      n = 1 << m;
      s = fwd ? 16 : 15;
      clipped = 1'b0;
      for (int i = 0; i < n; i++) begin
        r = 0;
        for (int q = 0; q < m; q++) r = (r << 1) | ((i >> q) & 1);
        if (i < r) begin
          t = re_mem[i]; re_mem[i] = re_mem[r]; re_mem[r] = t;
          t = im_mem[i]; im_mem[i] = im_mem[r]; im_mem[r] = t;
        end
      end
      for (int l = 0; l < m; l++) begin
        for (j = 0; j < (1 << l); j++) begin
          c = tw_cos(j << (5 - l));
          ws = fwd ? -tw_sin(j << (5 - l)) : tw_sin(j << (5 - l));
          for (int i = j; i < n; i += (2 << l)) begin
            b = i + (1 << l);
            br = re_mem[b];
            bi = im_mem[b];
            tr = c * br - ws * bi;
            ti = c * bi + ws * br;
            ar = longint'(re_mem[i]) * 32768;
            ai = longint'(im_mem[i]) * 32768;
            re_mem[i] = round_clip(ar + tr, s);
            im_mem[i] = round_clip(ai + ti, s);
            re_mem[b] = round_clip(ar - tr, s);
            im_mem[b] = round_clip(ai - ti, s);
          end
        end
      end
    endfunction

    function void note_sample(logic signed [SW-1:0] re, logic signed [SW-1:0] im);
      int m, n;
      fft_bin_t e;
      m = (log2_len < 1) ? 1 : (log2_len > DEF_MAX_LOG2_POINTS) ? DEF_MAX_LOG2_POINTS
                                                               : int'(log2_len);
      n = 1 << m;
      re_mem[fill % MAXN] = re;
      im_mem[fill % MAXN] = im;
      fill = (fill + 1) % 128;
      if (fill < n) return;
      run_fft(m);
      frames++;
      if (clipped) sat_frames++;
      for (int k = 0; k < n; k++) begin
        e.re = re_mem[k];
        e.im = im_mem[k];
        e.last = (k == n - 1);
        e.sat = clipped;
        bins_due.push_back(e);
      end
      fill = 0;
    endfunction

    function void check_bin(fft_bin_t got);
      fft_bin_t e;
      bins_seen++;
      if (bins_due.size() == 0) begin
        $error("unexpected result beat: real %0d imag %0d", got.re, got.im);
        errors++;
        return;
      end
      e = bins_due.pop_front();
      if (got.re !== e.re) begin
        $error("result_real expected %0d got %0d", e.re, got.re); errors++;
      end
      if (got.im !== e.im) begin
        $error("result_imag expected %0d got %0d", e.im, got.im); errors++;
      end
      if (got.last !== e.last) begin
        $error("last_result expected %0b got %0b", e.last, got.last); errors++;
      end
      if (got.sat !== e.sat) begin
        $error("saturated expected %0b got %0b", e.sat, got.sat); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_idx = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_val = '0;
  int gap_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;

  r2fft_stream_if #(.SAMPLE_WIDTH(SW)) in_ch();
  r2fft_stream_if #(.SAMPLE_WIDTH(SW)) out_ch();

  fft_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  radix2_complex_fft uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_sample_real(in_ch.sample_real), .in_sample_imag(in_ch.sample_imag),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_result_real(out_ch.sample_real), .out_result_imag(out_ch.sample_imag),
    .out_last_result(out_ch.last_result), .out_saturated(out_ch.saturated),
    .cfg_write_enable(cfg_we), .cfg_index(cfg_idx), .cfg_data(cfg_val)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample_real = '0;
    in_ch.sample_imag = '0;
    in_ch.last_result = 1'b0;
    in_ch.saturated = 1'b0;
    out_ch.ready = 1'b0;
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    fft_bin_t got;
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_sample(in_ch.sample_real, in_ch.sample_imag);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.re = out_ch.sample_real;
      got.im = out_ch.sample_imag;
      got.last = out_ch.last_result;
      got.sat = out_ch.saturated;
      sb.check_bin(got);
    end
  end

  task automatic send_sample(logic signed [SW-1:0] re, logic signed [SW-1:0] im);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_real <= re;
    in_ch.sample_imag <= im;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.bins_due.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_val <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [SW-1:0] pick_value();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return SW'($signed($urandom_range(512)) - 256);
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic send_frame(int m);
    for (int i = 0; i < (1 << m); i++) send_sample(pick_value(), pick_value());
  endtask

  initial begin
    int m, phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two-point frames at the extremes, forward then inverse.
    write_reg(REG_LOG2_POINTS, 3'd1);
    send_sample(16'sh7fff, 16'sh7fff); send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000); send_sample(16'sh7fff, 16'sh0000);
    wait_idle();
    write_reg(REG_FORWARD, 3'd0);
    send_sample(16'sh7fff, 16'sh8000); send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh0000, 16'sh0000); send_sample(16'sh0000, 16'sh0000);
    wait_idle();
    // A length of zero behaves as two points, seven as the full 64.
    write_reg(REG_LOG2_POINTS, 3'd0);
    send_sample(16'sh8000, 16'sh7fff); send_sample(16'sh8000, 16'sh8000);
    wait_idle();
    // Length shrinks while a frame is partly loaded: the next sample closes the frame.
    write_reg(REG_LOG2_POINTS, 3'd3);
    send_sample(16'sh1234, -16'sh0100); send_sample(16'sh4000, 16'sh0001);
    send_sample(-16'sh4000, 16'sh7fff);
    wait_idle();
    write_reg(REG_LOG2_POINTS, 3'd1);
    write_reg(REG_FORWARD, 3'd1);
    send_sample(16'sh0010, 16'sh0020);
    wait_idle();
    // Direction flips mid-frame; the setting at the closing sample counts.
    write_reg(REG_LOG2_POINTS, 3'd2);
    send_sample(16'sh7fff, 16'sh7fff); send_sample(16'sh7fff, 16'sh7fff);
    wait_idle();
    write_reg(REG_FORWARD, 3'd0);
    send_sample(16'sh7fff, 16'sh7fff); send_sample(16'sh7fff, 16'sh7fff);
    wait_idle();

    // Random phases; most frames are short, a few use the full length.
    phase = 0;
    while (items_sent < 240) begin
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 53; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 53; end
        default: begin gap_pct = 9; stall_pct = 9; end
      endcase
      case ($urandom_range(9))
        0: m = 7;
        1: m = 6;
        2: m = 0;
        default: m = $urandom_range(5, 1);
      endcase
      write_reg(REG_LOG2_POINTS, m[2:0]);
      write_reg(REG_FORWARD, 3'($urandom_range(1)));
      if (m == 0) m = 1;
      if (m == 7) m = 6;
      repeat ($urandom_range(3, 1)) send_frame(m);
      wait_idle();
      phase++;
    end

    $display("Covered %0d samples in %0d frames, %0d bins checked, %0d frames saturated.",
             items_sent, sb.frames, sb.bins_seen, sb.sat_frames);
    if (sb.errors == 0 && sb.bins_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
